[src/cwtd_pkg.sv]
// cwtd_pkg: types, codes and constants of the clock and temperature display core
// transfer payload structs, event codes, reset values and the seven-segment font
// no dependencies
package cwtd_pkg;

  typedef struct packed {
    logic [2:0] func;
    logic [9:0] adc_sample;
  } in_item_t;

  typedef struct packed {
    logic [6:0] segment_pattern;
    logic [3:0] digit_enable;
    logic [4:0] hours_now;
    logic [5:0] minutes_now;
    logic [5:0] seconds_now;
    logic [1:0] mode_now;
    logic [5:0] temperature_now;
  } out_item_t;

  typedef enum logic [2:0] {
    EV_DISPLAY = 3'd0,
    EV_TIME    = 3'd1,
    EV_MODE    = 3'd2,
    EV_SET     = 3'd3,
    EV_TEMP    = 3'd4
  } event_kind_t;

  localparam logic [1:0] MODE_RUN     = 2'd0;
  localparam logic [1:0] MODE_SET_HR  = 2'd1;
  localparam logic [1:0] MODE_SET_MIN = 2'd2;

  localparam int unsigned APB_AW = 2;
  localparam logic [APB_AW-1:0] REG_TPS_ADDR = 2'd0;

  localparam logic [7:0] TPS_RESET     = 8'd20;
  localparam logic [5:0] MINUTES_RESET = 6'd8;
  localparam logic [4:0] HOURS_RESET   = 5'd23;

  // adc*33/1023 is adc/31, done as multiply by ceil(2^15/31) and shift
  localparam int unsigned TEMP_SHIFT = 15;
  localparam logic [10:0] TEMP_RECIP = 11'd1058;

  localparam logic [6:0] SEG_DEGREE = 7'h63;
  localparam logic [6:0] SEG_C      = 7'h39;

  function automatic logic [6:0] seg_glyph(input logic [3:0] d);
    logic [6:0] p;
    unique case (d)
      4'd0:    p = 7'h3F;
      4'd1:    p = 7'h06;
      4'd2:    p = 7'h5B;
      4'd3:    p = 7'h4F;
      4'd4:    p = 7'h66;
      4'd5:    p = 7'h6D;
      4'd6:    p = 7'h7D;
      4'd7:    p = 7'h07;
      4'd8:    p = 7'h7F;
      4'd9:    p = 7'h6F;
      default: p = 7'h00;
    endcase
    return p;
  endfunction

  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [2:0] t;
    priority if (v >= 6'd60) t = 3'd6;
    else if (v >= 6'd50)     t = 3'd5;
    else if (v >= 6'd40)     t = 3'd4;
    else if (v >= 6'd30)     t = 3'd3;
    else if (v >= 6'd20)     t = 3'd2;
    else if (v >= 6'd10)     t = 3'd1;
    else                     t = 3'd0;
    return t;
  endfunction

  function automatic logic [3:0] units_of(input logic [5:0] v);
    logic [5:0] r;
    r = v - 6'(tens_of(v)) * 6'd10;
    return r[3:0];
  endfunction

endpackage

[src/clock_with_temperature_display_core.sv]
// clock_with_temperature_display_core: time-of-day clock with a multiplexed
// four-digit seven-segment display and a temperature readout
// depends on cwtd_pkg
//
// Usage:
//   in_*  : one event per transfer (display tick, time tick, mode button,
//           set button, temperature sample), valid/stall handshake.
//   out_* : one result per event: segment and digit drive plus the clock,
//           mode and temperature state after that event.
//   APB   : register 0 at byte address 0 holds ticks_per_second; write it
//           only while no event is in flight. pready is tied high.
//   After the accepting edge the event sits in the input register, then moves
//   into the result register, which is where the state update lands, and
//   out_valid rises. One event per cycle is sustained while out_stall is low;
//   the state update between the two registers is combinational.
//   A stalled result holds in the output register; the input register keeps
//   accepting until it too is full, then in_stall rises.
//   Synchronous reset clears both stages and loads the reset time 23:08:00,
//   mode run, temperature 0, display blank and ticks_per_second 20.
module clock_with_temperature_display_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  cwtd_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output cwtd_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cwtd_pkg::APB_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import cwtd_pkg::*;

  logic       s1_vld_r;
  in_item_t   s1_item_r;
  logic       out_valid_r;
  out_item_t  out_data_r;
  logic       s2_load, s1_adv, in_fire;

  logic [7:0] tps_r;
  logic [7:0] tick_r, tick_nxt;
  logic [5:0] sec_r, sec_nxt;
  logic [5:0] min_r, min_nxt;
  logic [4:0] hr_r, hr_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic [5:0] temp_r, temp_nxt;
  logic [1:0] pos_r, pos_nxt;
  logic [6:0] seg_r, seg_nxt;
  logic [3:0] dig_r, dig_nxt;

  logic        show_temp;
  logic [20:0] temp_prod;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr == REG_TPS_ADDR) ? {24'd0, tps_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_TPS_ADDR)) begin
      tps_r <= pwdata[7:0];
    end
  end

  // two-register pipeline; state commits as an item moves into the result register
  assign s2_load  = !out_valid_r || !out_stall;
  assign s1_adv   = s1_vld_r && s2_load;
  assign in_stall = s1_vld_r && !s2_load;
  assign in_fire  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_fire) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_data;
    end
  end

  assign show_temp = (mode_r == MODE_RUN) && (units_of(sec_r) <= 4'd5);
  assign temp_prod = 21'(s1_item_r.adc_sample) * 21'(TEMP_RECIP);

  always_comb begin
    tick_nxt = tick_r;
    sec_nxt  = sec_r;
    min_nxt  = min_r;
    hr_nxt   = hr_r;
    mode_nxt = mode_r;
    temp_nxt = temp_r;
    pos_nxt  = pos_r;
    seg_nxt  = seg_r;
    dig_nxt  = dig_r;
    unique case (s1_item_r.func)
      EV_DISPLAY: begin
        unique case (pos_r)
          2'd0: seg_nxt = show_temp ? seg_glyph(4'(tens_of(temp_r)))
                                    : seg_glyph(4'(tens_of({1'b0, hr_r})));
          2'd1: seg_nxt = show_temp ? seg_glyph(units_of(temp_r))
                                    : seg_glyph(units_of({1'b0, hr_r}));
          2'd2: seg_nxt = show_temp ? SEG_DEGREE : seg_glyph(4'(tens_of(min_r)));
          2'd3: seg_nxt = show_temp ? SEG_C : seg_glyph(units_of(min_r));
        endcase
        dig_nxt = 4'd1 << pos_r;
        pos_nxt = pos_r + 2'd1;
      end
      EV_TIME: begin
        tick_nxt = tick_r + 8'd1;
        if (tick_nxt == tps_r) begin
          tick_nxt = 8'd0;
          sec_nxt  = sec_r + 6'd1;
        end
        if (sec_nxt >= 6'd60) begin
          sec_nxt = 6'd0;
          min_nxt = min_r + 6'd1;
        end
        if (min_nxt >= 6'd60) begin
          min_nxt = 6'd0;
          hr_nxt  = hr_r + 5'd1;
        end
        if (hr_nxt >= 5'd24) begin
          hr_nxt = 5'd0;
        end
      end
      EV_MODE: begin
        mode_nxt = (mode_r == MODE_SET_MIN) ? MODE_RUN : mode_r + 2'd1;
      end
      EV_SET: begin
        sec_nxt = 6'd0;
        if (mode_r == MODE_SET_HR) begin
          hr_nxt = (hr_r >= 5'd23) ? 5'd0 : hr_r + 5'd1;
        end else begin
          min_nxt = (min_r >= 6'd59) ? 6'd0 : min_r + 6'd1;
        end
      end
      EV_TEMP: begin
        temp_nxt = 6'(temp_prod >> TEMP_SHIFT);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= 8'd0;
      sec_r  <= 6'd0;
      min_r  <= MINUTES_RESET;
      hr_r   <= HOURS_RESET;
      mode_r <= MODE_RUN;
      temp_r <= 6'd0;
      pos_r  <= 2'd0;
      seg_r  <= 7'd0;
      dig_r  <= 4'd0;
    end else if (s1_adv) begin
      tick_r <= tick_nxt;
      sec_r  <= sec_nxt;
      min_r  <= min_nxt;
      hr_r   <= hr_nxt;
      mode_r <= mode_nxt;
      temp_r <= temp_nxt;
      pos_r  <= pos_nxt;
      seg_r  <= seg_nxt;
      dig_r  <= dig_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= '{segment_pattern: seg_nxt, digit_enable: dig_nxt,
                      hours_now: hr_nxt, minutes_now: min_nxt,
                      seconds_now: sec_nxt, mode_now: mode_nxt,
                      temperature_now: temp_nxt};
    end
  end

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    (hr_r < 5'd24) && (min_r < 6'd60) && (sec_r < 6'd60) && (temp_r <= 6'd33))
    else $error("clock or temperature state out of range");

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != 2'd3)
    else $error("mode register holds an unused code");

  a_digit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(dig_r))
    else $error("digit select is not one-hot");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_vld_r && out_valid_r && out_stall))
    else $error("input stalled while the pipeline has room");

  a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("item left the input register without a result");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking testbench for clock_with_temperature_display_core
// drives events and register writes, predicts each result and checks them in order
// depends on cwtd_pkg and the core
module tb;
  import cwtd_pkg::*;

  localparam int unsigned IDLE_PCT       = 26;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned PHASE_EVENTS   = 50;
  localparam logic [2:0]  EV_UNUSED_FIRST = 3'(EV_TEMP) + 3'd1;
  localparam logic [2:0]  EV_UNUSED_LAST  = '1;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [APB_AW-1:0]   paddr     = '0;
  logic [31:0]         pwdata    = '0;
  logic [31:0]         prdata;
  logic                pready;

  clock_with_temperature_display_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted clock state
  logic [7:0] tps_reg;
  logic [7:0] tick_cnt;
  logic [5:0] sec_cnt;
  logic [5:0] min_cnt;
  logic [4:0] hr_cnt;
  logic [1:0] mode_cnt;
  logic [5:0] temp_deg;
  logic [2:0] digit_pos;
  logic [6:0] seg_hold;
  logic [3:0] dig_hold;
  logic [6:0] seg_font [10] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
                                7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};

  out_item_t   display_q [$];
  out_item_t   want;
  int unsigned mismatches   = 0;
  int unsigned events_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned tps_writes   = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idle      = 1'b0;

  function automatic void clock_reset();
    tps_reg   = TPS_RESET;
    tick_cnt  = '0;
    sec_cnt   = '0;
    min_cnt   = MINUTES_RESET;
    hr_cnt    = HOURS_RESET;
    mode_cnt  = MODE_RUN;
    temp_deg  = '0;
    digit_pos = '0;
    seg_hold  = '0;
    dig_hold  = '0;
  endfunction

  function automatic out_item_t clock_advance(input in_item_t ev);
    logic [2:0] d;
    logic       show_temp;
    logic [6:0] pat;
    out_item_t  r;
    case (ev.func)
      EV_DISPLAY: begin
        d = {1'b0, digit_pos[1:0]} + 3'd1;
        show_temp = (mode_cnt == MODE_RUN) && ((sec_cnt % 10) <= 5);
        if (show_temp) begin
          case (d)
            3'd1:    pat = seg_font[temp_deg / 10];
            3'd2:    pat = seg_font[temp_deg % 10];
            3'd3:    pat = SEG_DEGREE;
            default: pat = SEG_C;
          endcase
        end else begin
          case (d)
            3'd1:    pat = seg_font[hr_cnt / 10];
            3'd2:    pat = seg_font[hr_cnt % 10];
            3'd3:    pat = seg_font[min_cnt / 10];
            default: pat = seg_font[min_cnt % 10];
          endcase
        end
        seg_hold  = pat;
        dig_hold  = 4'b0001 << (d - 3'd1);
        digit_pos = (d == 3'd4) ? 3'd0 : d;
      end
      EV_TIME: begin
        // prescaler runs modulo 256, so a lowered or zero setting wraps first
        tick_cnt = tick_cnt + 8'd1;
        if (tick_cnt == tps_reg) begin
          sec_cnt  = sec_cnt + 6'd1;
          tick_cnt = '0;
        end
        if (sec_cnt >= 60) begin
          sec_cnt = '0;
          min_cnt = min_cnt + 6'd1;
        end
        if (min_cnt >= 60) begin
          min_cnt = '0;
          hr_cnt  = hr_cnt + 5'd1;
        end
        if (hr_cnt >= 24) hr_cnt = '0;
      end
      EV_MODE: begin
        mode_cnt = (mode_cnt == MODE_SET_MIN) ? MODE_RUN : mode_cnt + 2'd1;
      end
      EV_SET: begin
        // no carry from minutes into hours here
        sec_cnt = '0;
        if (mode_cnt == MODE_SET_HR) hr_cnt = (hr_cnt == 23) ? 5'd0 : hr_cnt + 5'd1;
        else min_cnt = (min_cnt == 59) ? 6'd0 : min_cnt + 6'd1;
      end
      EV_TEMP: begin
        temp_deg = 6'((int'(ev.adc_sample) * 33) / 1023);
      end
      default: ;
    endcase
    r.segment_pattern = seg_hold;
    r.digit_enable    = dig_hold;
    r.hours_now       = hr_cnt;
    r.minutes_now     = min_cnt;
    r.seconds_now     = sec_cnt;
    r.mode_now        = mode_cnt;
    r.temperature_now = temp_deg;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected 0x%0h, got 0x%0h at %0t", what, exp_v, got_v, $realtime);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (display_q.size() == 0) begin
        check_field("result with nothing outstanding", 32'd0, 32'd1);
      end else begin
        want = display_q.pop_front();
        check_field("segment_pattern", 32'(want.segment_pattern),
                    32'(out_data.segment_pattern));
        check_field("digit_enable", 32'(want.digit_enable),
                    32'(out_data.digit_enable));
        check_field("hours_now", 32'(want.hours_now), 32'(out_data.hours_now));
        check_field("minutes_now", 32'(want.minutes_now),
                    32'(out_data.minutes_now));
        check_field("seconds_now", 32'(want.seconds_now),
                    32'(out_data.seconds_now));
        check_field("mode_now", 32'(want.mode_now), 32'(out_data.mode_now));
        check_field("temperature_now", 32'(want.temperature_now),
                    32'(out_data.temperature_now));
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= rst_n && !no_idle && ($urandom_range(99) < IDLE_PCT);
  end

  // watchdog on cycles without any transfer or register access
  always @(posedge clk) begin
    if (!rst_n || psel || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles, %0d results outstanding",
               quiet_cycles, display_q.size());
      $display("FAIL clock_with_temperature_display_core");
      $finish;
    end
  end

  task automatic send_event(input logic [2:0] kind, input logic [9:0] adc);
    in_item_t item;
    item.func       = kind;
    item.adc_sample = adc;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    display_q.push_back(clock_advance(item));
    events_sent++;
  endtask

  // well-formed sequences get display ticks sprinkled in
  task automatic send_mixed(input logic [2:0] kind);
    if ($urandom_range(3) == 0) send_event(EV_DISPLAY, 10'($urandom));
    send_event(kind, 10'($urandom));
  endtask

  task automatic goto_mode(input logic [1:0] m);
    while (mode_cnt != m) send_mixed(EV_MODE);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (display_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_access(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_ticks_per_second(input logic [7:0] v);
    logic [31:0] rd;
    drain_results();
    reg_access(1'b1, REG_TPS_ADDR, {24'd0, v}, rd);
    tps_reg = v;
    tps_writes++;
    reg_access(1'b0, REG_TPS_ADDR, 32'd0, rd);
    check_field("ticks_per_second readback", 32'(v), 32'(rd[7:0]));
  endtask

  function automatic logic [2:0] pick_event();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return EV_DISPLAY;
    if (r < 62) return EV_TIME;
    if (r < 72) return EV_MODE;
    if (r < 84) return EV_SET;
    if (r < 95) return EV_TEMP;
    return 3'($urandom_range(EV_UNUSED_LAST, EV_UNUSED_FIRST));
  endfunction

  // a third of samples sit on a step of the degree scale
  function automatic logic [9:0] pick_adc();
    int k;
    if ($urandom_range(2) != 0) return 10'($urandom);
    k = 31 * int'($urandom_range(33)) - int'($urandom_range(1));
    return (k < 0) ? 10'd0 : 10'(k);
  endfunction

  task automatic test_register_access();
    logic [31:0] rd;
    reg_access(1'b0, REG_TPS_ADDR, 32'd0, rd);
    check_field("ticks_per_second after reset", 32'(TPS_RESET), 32'(rd[7:0]));
    set_ticks_per_second(8'd255);
    set_ticks_per_second(8'd0);
    set_ticks_per_second(8'd1);
  endtask

  task automatic test_directed_events();
    set_ticks_per_second(8'd1);
    send_event(EV_UNUSED_FIRST, '0);     // reset state, display still blank
    send_event(EV_TEMP, 10'd1023);
    repeat (4) send_event(EV_DISPLAY, '1);
    send_event(EV_TEMP, 10'd0);
    send_event(EV_TEMP, 10'd30);
    send_event(EV_TEMP, 10'd31);
    send_event(EV_TEMP, 10'd1022);
    send_event(EV_MODE, '0);
    repeat (4) send_event(EV_DISPLAY, '0);
    send_event(EV_SET, '0);              // hour 23 wraps to 0
    send_event(EV_MODE, '0);
    send_event(EV_SET, '0);
    send_event(EV_MODE, '0);             // back to run mode
    send_event(EV_UNUSED_LAST, '1);
    repeat (6) send_event(EV_TIME, '0);
    send_event(EV_DISPLAY, '0);          // seconds ending in 6 show the time
    drain_results();
  endtask

  task automatic test_set_and_rollover();
    set_ticks_per_second(8'd1);
    goto_mode(MODE_SET_MIN);
    while (min_cnt != 59) send_mixed(EV_SET);
    send_mixed(EV_SET);
    while (min_cnt != 59) send_mixed(EV_SET);
    goto_mode(MODE_SET_HR);
    while (hr_cnt != 23) send_mixed(EV_SET);
    goto_mode(MODE_RUN);
    // 23:59 plus a minute of ticks carries through to midnight
    while (!(hr_cnt == 0 && min_cnt == 0)) send_mixed(EV_TIME);
    drain_results();
  endtask

  task automatic test_prescaler_wrap();
    logic [5:0] s;
    set_ticks_per_second(8'd255);
    repeat (40) send_mixed(EV_TIME);
    set_ticks_per_second(8'd3);
    s = sec_cnt;
    while (sec_cnt == s) send_mixed(EV_TIME);
    repeat (8) send_mixed(EV_TIME);
    set_ticks_per_second(8'd0);
    s = sec_cnt;
    while (sec_cnt == s) send_mixed(EV_TIME);
    drain_results();
  endtask

  task automatic test_random_traffic();
    logic [7:0] tps_set [6];
    tps_set = '{8'd1, 8'd2, 8'd7, 8'd20, 8'd255, 8'd1};
    tps_set[5] = 8'($urandom_range(255, 1));
    for (int p = 0; p < 6; p++) begin
      set_ticks_per_second(tps_set[p]);
      no_idle = (p == 2);
      repeat (PHASE_EVENTS) send_event(pick_event(), pick_adc());
    end
    drain_results();
    no_idle = 1'b0;
  endtask

  initial begin
    clock_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_access();
    test_directed_events();
    test_set_and_rollover();
    test_prescaler_wrap();
    test_random_traffic();
    drain_results();
    $display("sent %0d events, checked %0d results across %0d prescaler settings",
             events_sent, results_seen, tps_writes);
    $display("mismatches counted: %0d", mismatches);
    if (mismatches == 0 && display_q.size() == 0) begin
      $display("PASS clock_with_temperature_display_core");
    end else begin
      $display("FAIL clock_with_temperature_display_core");
    end
    $finish;
  end

endmodule

[clock_with_temperature_display_core.f]
src/cwtd_pkg.sv
src/clock_with_temperature_display_core.sv
tb/tb.sv
